// File: design/slts_pkg.sv
// Package for the scanline timing and status block.
// Holds widths, register indexes, default timing constants and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slts_pkg;

   // Field and state widths.
   localparam int ACC_W      = 13;
   localparam int ELAPSED_W  = 12;
   localparam int LINE_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // Default display timing.
   localparam int DEF_LINE_CYCLES = 1232;
   localparam int DEF_DRAW_CYCLES = 960;
   localparam int DEF_LAST_LINE   = 227;
   localparam int DEF_VBLANK_LINE = 160;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_VCOUNT_COMPARE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VBLANK_IRQ_EN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HBLANK_IRQ_EN  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VMATCH_IRQ_EN  = 2'd3;

   typedef struct packed {
      logic [LINE_W-1:0] vcount_compare;
      logic              vblank_irq_enable;
      logic              hblank_irq_enable;
      logic              vmatch_irq_enable;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // add the elapsed cycles of a new transaction
      logic step;   // retire one whole line from the accumulator
      logic emit;   // copy the status into the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic line_pending;   // accumulator still holds a whole line
   } sts_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_LINES
   } state_type;

endpackage

`default_nettype wire

// File: design/slts_ctrl.sv
// Controller state machine of the scanline timing block.
// Depends on slts_pkg; drives the datapath commands and the handshakes.
`timescale 1ns / 1ps
`default_nettype none

module slts_ctrl
   import slts_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_LINES;
            end
         end
         ST_LINES: begin
            if (sts.line_pending) begin
               cmd.step = 1'b1;
            end else if (!rsp_valid_ff || rsp_ready) begin
               // The result register is free or is being drained this cycle.
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: design/slts_dpath.sv
// Datapath of the scanline timing block: accumulator, line counter, flags.
// Depends on slts_pkg; steered by the command struct from slts_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module slts_dpath
   import slts_pkg::*;
#(
   parameter int LINE_CYCLES = DEF_LINE_CYCLES,
   parameter int DRAW_CYCLES = DEF_DRAW_CYCLES,
   parameter int LAST_LINE   = DEF_LAST_LINE,
   parameter int VBLANK_LINE = DEF_VBLANK_LINE
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cmd_type              cmd,
   output sts_type                   sts,
   input  wire cfg_type              cfg,
   input  wire logic [ELAPSED_W-1:0] elapsed_cycles,
   output logic [LINE_W-1:0]         rsp_line_number,
   output logic                      rsp_hblank_flag,
   output logic                      rsp_vblank_flag,
   output logic                      rsp_match_flag,
   output logic                      rsp_irq_vblank,
   output logic                      rsp_irq_hblank,
   output logic                      rsp_irq_vmatch,
   output logic                      rsp_dma_vblank_trigger
);

   localparam logic [ACC_W-1:0]  LineCyc   = ACC_W'(LINE_CYCLES);
   localparam logic [ACC_W-1:0]  DrawCyc   = ACC_W'(DRAW_CYCLES);
   localparam logic [LINE_W:0]   LastLine  = (LINE_W + 1)'(LAST_LINE);
   localparam logic [LINE_W-1:0] VblLine   = LINE_W'(VBLANK_LINE);

   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic              hblank_ff, hblank_in;
   logic              vblank_ff, vblank_in;
   logic              match_ff, match_in;
   logic              irq_v_ff, irq_v_in;
   logic              irq_h_ff, irq_h_in;
   logic              irq_m_ff, irq_m_in;
   logic              dma_ff, dma_in;

   logic [LINE_W-1:0] out_line_ff;
   logic              out_hblank_ff, out_vblank_ff, out_match_ff;
   logic              out_irq_v_ff, out_irq_h_ff, out_irq_m_ff, out_dma_ff;

   logic [ACC_W-1:0]  acc_sum;
   logic [LINE_W:0]   line_inc;
   logic [LINE_W-1:0] line_next;

   assign acc_sum   = acc_ff + ACC_W'(elapsed_cycles);
   assign line_inc  = {1'b0, line_ff} + (LINE_W + 1)'(1);
   assign line_next = (line_inc > LastLine) ? '0 : line_inc[LINE_W-1:0];

   assign sts.line_pending = (acc_ff >= LineCyc);

   always_comb begin
      acc_in    = acc_ff;
      line_in   = line_ff;
      hblank_in = hblank_ff;
      vblank_in = vblank_ff;
      match_in  = match_ff;
      irq_v_in  = irq_v_ff;
      irq_h_in  = irq_h_ff;
      irq_m_in  = irq_m_ff;
      dma_in    = dma_ff;

      if (cmd.load) begin
         // The hblank test sees the sum before any line is retired.
         acc_in    = acc_sum;
         hblank_in = (acc_sum >= DrawCyc);
         irq_h_in  = (acc_sum >= DrawCyc) && !hblank_ff && cfg.hblank_irq_enable;
         irq_v_in  = 1'b0;
         irq_m_in  = 1'b0;
         dma_in    = 1'b0;
      end else if (cmd.step) begin
         acc_in  = acc_ff - LineCyc;
         line_in = line_next;
         if (line_next == VblLine) begin
            vblank_in = 1'b1;
            irq_v_in  = irq_v_ff | cfg.vblank_irq_enable;
            dma_in    = 1'b1;
         end else if (line_next == '0) begin
            vblank_in = 1'b0;
         end
         match_in = (line_next == cfg.vcount_compare);
         irq_m_in = irq_m_ff | ((line_next == cfg.vcount_compare) && cfg.vmatch_irq_enable);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         line_ff   <= '0;
         hblank_ff <= 1'b0;
         vblank_ff <= 1'b0;
         match_ff  <= 1'b0;
         irq_v_ff  <= 1'b0;
         irq_h_ff  <= 1'b0;
         irq_m_ff  <= 1'b0;
         dma_ff    <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         line_ff   <= line_in;
         hblank_ff <= hblank_in;
         vblank_ff <= vblank_in;
         match_ff  <= match_in;
         irq_v_ff  <= irq_v_in;
         irq_h_ff  <= irq_h_in;
         irq_m_ff  <= irq_m_in;
         dma_ff    <= dma_in;
      end
   end

   // Result register, loaded once per transaction.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_line_ff   <= line_ff;
         out_hblank_ff <= hblank_ff;
         out_vblank_ff <= vblank_ff;
         out_match_ff  <= match_ff;
         out_irq_v_ff  <= irq_v_ff;
         out_irq_h_ff  <= irq_h_ff;
         out_irq_m_ff  <= irq_m_ff;
         out_dma_ff    <= dma_ff;
      end
   end

   assign rsp_line_number        = out_line_ff;
   assign rsp_hblank_flag        = out_hblank_ff;
   assign rsp_vblank_flag        = out_vblank_ff;
   assign rsp_match_flag         = out_match_ff;
   assign rsp_irq_vblank         = out_irq_v_ff;
   assign rsp_irq_hblank         = out_irq_h_ff;
   assign rsp_irq_vmatch         = out_irq_m_ff;
   assign rsp_dma_vblank_trigger = out_dma_ff;

endmodule

`default_nettype wire

// File: design/scanline_timing_status.sv
// Scanline timing and display status generator.
//
// Input channel (req_*): each transaction carries req_elapsed_cycles, the
// number of clock cycles that passed since the previous transaction. The
// block adds it to the cycle count within the current line, updates the
// hblank flag, then retires whole lines one at a time and updates the line
// number, vblank flag and line-match flag. Result channel (rsp_*): exactly
// one result transaction per input transaction, carrying the line number,
// the three status flags and the interrupt and vblank DMA pulses for that
// step. Configuration port (csr_*): the compare line and three interrupt
// enables, written only while the block is idle; the user must keep to
// that, since the block itself does not enforce it.
// After the accepting edge the datapath retires the N whole lines that the
// transaction brings, subtracting one line period per cycle, then loads the
// result register once it is free, which raises rsp_valid. With the default
// timing N is at most 4; a new item is accepted in the cycle after its
// result is loaded.
//
// Reset clears the line count, the accumulator, all flags, the CSRs and
// rsp_valid, but not the result register. When the receiver stalls the
// result waits in its output register; the block still accepts and works
// on one more transaction, holding it until the output register drains.
`timescale 1ns / 1ps
`default_nettype none

module scanline_timing_status
   import slts_pkg::*;
#(
   parameter int LINE_CYCLES = DEF_LINE_CYCLES,
   parameter int DRAW_CYCLES = DEF_DRAW_CYCLES,
   parameter int LAST_LINE   = DEF_LAST_LINE,
   parameter int VBLANK_LINE = DEF_VBLANK_LINE
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [ELAPSED_W-1:0]  req_elapsed_cycles,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [LINE_W-1:0]          rsp_line_number,
   output logic                       rsp_hblank_flag,
   output logic                       rsp_vblank_flag,
   output logic                       rsp_match_flag,
   output logic                       rsp_irq_vblank,
   output logic                       rsp_irq_hblank,
   output logic                       rsp_irq_vmatch,
   output logic                       rsp_dma_vblank_trigger,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;
   sts_type sts;

   // Configuration registers; each keeps only the bits of its own width.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_VCOUNT_COMPARE: cfg_in.vcount_compare    = csr_write_data[LINE_W-1:0];
            CSR_VBLANK_IRQ_EN:  cfg_in.vblank_irq_enable = csr_write_data[0];
            CSR_HBLANK_IRQ_EN:  cfg_in.hblank_irq_enable = csr_write_data[0];
            CSR_VMATCH_IRQ_EN:  cfg_in.vmatch_irq_enable = csr_write_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   slts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   slts_dpath #(
      .LINE_CYCLES (LINE_CYCLES),
      .DRAW_CYCLES (DRAW_CYCLES),
      .LAST_LINE   (LAST_LINE),
      .VBLANK_LINE (VBLANK_LINE)
   ) u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .cfg                    (cfg_ff),
      .elapsed_cycles         (req_elapsed_cycles),
      .rsp_line_number        (rsp_line_number),
      .rsp_hblank_flag        (rsp_hblank_flag),
      .rsp_vblank_flag        (rsp_vblank_flag),
      .rsp_match_flag         (rsp_match_flag),
      .rsp_irq_vblank         (rsp_irq_vblank),
      .rsp_irq_hblank         (rsp_irq_hblank),
      .rsp_irq_vmatch         (rsp_irq_vmatch),
      .rsp_dma_vblank_trigger (rsp_dma_vblank_trigger)
   );

endmodule

`default_nettype wire

// File: design/slts_checker.sv
// Port-level assertions for the scanline timing block and their binding.
// Depends on slts_pkg; attaches to scanline_timing_status by a bind.
`timescale 1ns / 1ps
`default_nettype none

module slts_checker
   import slts_pkg::*;
#(
   parameter int LAST_LINE = DEF_LAST_LINE
)
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [LINE_W-1:0] rsp_line_number,
   input wire logic              rsp_hblank_flag,
   input wire logic              rsp_vblank_flag,
   input wire logic              rsp_irq_hblank,
   input wire logic              rsp_dma_vblank_trigger
);

   // A stalled result transaction keeps its line number.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_line_number))
      else $error("result transaction changed while stalled");

   // Line number never goes past the last line.
   a_line_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_line_number} <= (LINE_W + 1)'(LAST_LINE)))
      else $error("line number beyond last line");

   // A vblank DMA pulse only comes with the vblank flag set.
   a_dma_vblank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dma_vblank_trigger |-> rsp_vblank_flag)
      else $error("vblank DMA pulse without vblank flag");

   // The hblank interrupt only comes with the hblank flag set. The match interrupt
   // has no such rule, since a match on a middle line can end with the flag cleared.
   a_irq_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_irq_hblank |-> rsp_hblank_flag)
      else $error("hblank interrupt pulse without its status flag");

   // No result is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind scanline_timing_status slts_checker #(
   .LAST_LINE (LAST_LINE)
) u_slts_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_valid),
   .rsp_ready              (rsp_ready),
   .rsp_line_number        (rsp_line_number),
   .rsp_hblank_flag        (rsp_hblank_flag),
   .rsp_vblank_flag        (rsp_vblank_flag),
   .rsp_irq_hblank         (rsp_irq_hblank),
   .rsp_dma_vblank_trigger (rsp_dma_vblank_trigger)
);

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for scanline_timing_status.
// Depends on slts_pkg and the scanline_timing_status RTL with slts_ctrl and slts_dpath.
`timescale 1ns / 1ps

module testbench;
   import slts_pkg::*;

   // The block is built with its default timing, and the scanline model uses the same values.
   localparam int LINE_PERIOD = DEF_LINE_CYCLES;
   localparam int DRAW_PERIOD = DEF_DRAW_CYCLES;
   localparam int FINAL_LINE  = DEF_LAST_LINE;
   localparam int VBLANK_AT   = DEF_VBLANK_LINE;

   // A run that is working never gets close to this time in ns.
   localparam int RUN_LIMIT_NS = 4_000_000;

   // Status that one result transaction carries.
   typedef struct packed {
      logic [LINE_W-1:0] line_number;
      logic              hblank_flag;
      logic              vblank_flag;
      logic              match_flag;
      logic              irq_vblank;
      logic              irq_hblank;
      logic              irq_vmatch;
      logic              dma_vblank_trigger;
   } scan_status_t;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [ELAPSED_W-1:0]  req_elapsed_cycles;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [LINE_W-1:0]     rsp_line_number;
   logic                  rsp_hblank_flag;
   logic                  rsp_vblank_flag;
   logic                  rsp_match_flag;
   logic                  rsp_irq_vblank;
   logic                  rsp_irq_hblank;
   logic                  rsp_irq_vmatch;
   logic                  rsp_dma_vblank_trigger;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   // The state of the scanline model. It is updated when a transaction is accepted.
   logic [ACC_W-1:0]  line_cycles_model;
   logic [LINE_W-1:0] line_model;
   logic              hblank_model;
   logic              vblank_model;
   logic              match_model;
   cfg_type           csr_model;

   // Status predicted for each accepted transaction, oldest first.
   scan_status_t status_expected_q[$];

   // These switches turn the random gaps on the input side and the output side on and off.
   bit req_pacing = 1'b0;
   bit rsp_pacing = 1'b0;

   int mismatch_count = 0;
   int results_seen   = 0;

   scanline_timing_status uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_elapsed_cycles     (req_elapsed_cycles),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_line_number        (rsp_line_number),
      .rsp_hblank_flag        (rsp_hblank_flag),
      .rsp_vblank_flag        (rsp_vblank_flag),
      .rsp_match_flag         (rsp_match_flag),
      .rsp_irq_vblank         (rsp_irq_vblank),
      .rsp_irq_hblank         (rsp_irq_hblank),
      .rsp_irq_vmatch         (rsp_irq_vmatch),
      .rsp_dma_vblank_trigger (rsp_dma_vblank_trigger),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The run stops here if a transaction hangs. A timeout always counts as a failure.
   initial begin
      #(RUN_LIMIT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

   // Advance the scanline model by one transaction and return the status it should report.
   // First the hblank flag is decided from the cycle count. After that, whole lines are
   // removed one at a time. Pulses from all those lines are ORed together, and the flags
   // keep the value from the last line.
   function automatic scan_status_t advance_scanline(logic [ELAPSED_W-1:0] elapsed);
      scan_status_t s;
      s = '0;
      line_cycles_model = line_cycles_model + ACC_W'(elapsed);
      if (line_cycles_model >= ACC_W'(DRAW_PERIOD)) begin
         if (!hblank_model) begin
            hblank_model = 1'b1;
            s.irq_hblank = csr_model.hblank_irq_enable;
         end
      end else begin
         hblank_model = 1'b0;
      end
      while (line_cycles_model >= ACC_W'(LINE_PERIOD)) begin
         line_cycles_model = line_cycles_model - ACC_W'(LINE_PERIOD);
         line_model = (int'(line_model) >= FINAL_LINE) ? '0 : line_model + 1'b1;
         if (line_model == LINE_W'(VBLANK_AT)) begin
            vblank_model = 1'b1;
            s.irq_vblank = s.irq_vblank | csr_model.vblank_irq_enable;
            s.dma_vblank_trigger = 1'b1;
         end else if (line_model == '0) begin
            vblank_model = 1'b0;
         end
         match_model = (line_model == csr_model.vcount_compare);
         s.irq_vmatch = s.irq_vmatch | (match_model & csr_model.vmatch_irq_enable);
      end
      s.line_number = line_model;
      s.hblank_flag = hblank_model;
      s.vblank_flag = vblank_model;
      s.match_flag  = match_model;
      return s;
   endfunction

   // Prints one line per mismatch and counts it. Printing stops after the first fifty so the
   // log stays short when the design is badly broken, but every mismatch is still counted.
   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 50)
         $display("%0t ns  mismatch: %s", $time, msg);
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want)
         report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                   results_seen, name, got, want));
   endtask

   // Every accepted result is checked against the oldest prediction. The handshake is
   // sampled at the rising edge, so the outputs are read before the edge changes them.
   always @(posedge clock) begin
      scan_status_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (status_expected_q.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no transaction pending",
                                      results_seen));
         end else begin
            want = status_expected_q.pop_front();
            check_field("line_number", rsp_line_number, want.line_number);
            check_field("hblank_flag", rsp_hblank_flag, want.hblank_flag);
            check_field("vblank_flag", rsp_vblank_flag, want.vblank_flag);
            check_field("match_flag", rsp_match_flag, want.match_flag);
            check_field("irq_vblank", rsp_irq_vblank, want.irq_vblank);
            check_field("irq_hblank", rsp_irq_hblank, want.irq_hblank);
            check_field("irq_vmatch", rsp_irq_vmatch, want.irq_vmatch);
            check_field("dma_vblank_trigger", rsp_dma_vblank_trigger,
                        want.dma_vblank_trigger);
         end
      end
   end

   // The result sink. When pacing is on, it holds ready low for a random number of cycles
   // before each result. The stall starts whether or not a result is already waiting, so
   // stalls land in every phase of the block's work. Ready only changes on the falling edge.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         stall = rsp_pacing ? $urandom_range(0, 17) : 0;
         @(negedge clock);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Offer one transaction after an optional random gap, then wait until it is accepted.
   // The task returns at the accepting edge. If the next call has no gap, valid stays high
   // across the boundary and only the payload changes.
   task automatic send_elapsed(logic [ELAPSED_W-1:0] elapsed);
      int gap;
      gap = req_pacing ? $urandom_range(0, 17) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_elapsed_cycles <= elapsed;
      do @(posedge clock); while (!req_ready);
      status_expected_q.push_back(advance_scanline(elapsed));
   endtask

   // Stop sending and wait until every predicted result has been checked.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (status_expected_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Write one register while the block is idle. For the one-bit enables the upper data
   // bits carry random junk, which the block has to ignore.
   task automatic write_csr(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         CSR_VCOUNT_COMPARE: csr_model.vcount_compare    = data;
         CSR_VBLANK_IRQ_EN:  csr_model.vblank_irq_enable = data[0];
         CSR_HBLANK_IRQ_EN:  csr_model.hblank_irq_enable = data[0];
         CSR_VMATCH_IRQ_EN:  csr_model.vmatch_irq_enable = data[0];
         default: ;
      endcase
   endtask

   function automatic logic [CSR_DATA_W-1:0] enable_word(logic en);
      return {(CSR_DATA_W - 1)'($urandom_range(0, 127)), en};
   endfunction

   // Elapsed count that brings the model's cycle count to exactly target. It falls back to
   // a random count when the target cannot be reached from where the count is now.
   function automatic logic [ELAPSED_W-1:0] elapsed_to_reach(int target);
      int delta;
      delta = target - int'(line_cycles_model);
      if (delta < 0 || delta > 4095)
         return ELAPSED_W'($urandom_range(0, 4095));
      return ELAPSED_W'(delta);
   endfunction

   // Field extremes and alternating bit patterns, sent while all interrupts are disabled.
   // The full count retires three lines in one step.
   task automatic test_field_extremes();
      send_elapsed(12'd0);
      send_elapsed(12'hFFF);
      send_elapsed(12'hAAA);
      send_elapsed(12'h555);
   endtask

   // Hblank edge detection. The interrupt fires only on the step where the flag rises.
   // When the cycle count reaches the end of the line, the line advances but the flag stays
   // as it was tested, and it only clears on the following step.
   task automatic test_hblank_edge();
      write_csr(CSR_HBLANK_IRQ_EN, enable_word(1'b1));
      send_elapsed(12'd0);
      send_elapsed(elapsed_to_reach(DRAW_PERIOD - 1));
      send_elapsed(12'd1);
      send_elapsed(elapsed_to_reach(LINE_PERIOD - 1));
      send_elapsed(12'd1);
      send_elapsed(12'd0);
   endtask

   // Line match behavior. The match flag holds when no line advances. When several lines
   // advance in one step, a match on a middle line still pulses the interrupt, but the flag
   // ends cleared. A compare value above the last line can never match.
   task automatic test_line_match();
      write_csr(CSR_VMATCH_IRQ_EN, enable_word(1'b1));
      write_csr(CSR_VCOUNT_COMPARE, line_model + 8'd1);
      send_elapsed(elapsed_to_reach(LINE_PERIOD));
      send_elapsed(12'd5);
      write_csr(CSR_VCOUNT_COMPARE, line_model + 8'd2);
      send_elapsed(12'hFFF);
      write_csr(CSR_VCOUNT_COMPARE, 8'hFF);
      send_elapsed(12'hFFF);
      send_elapsed(12'hFFF);
   endtask

   // Random traffic over several register settings, the extremes among them. The elapsed
   // counts mix full-range values, small steps, counts that land exactly on the hblank and
   // line boundaries, and whole multiples of the line period, so that many full frames
   // (vblank entry and wrap to line zero) get exercised.
   task automatic test_random_frames();
      int segment_left;
      int pick;
      logic [CSR_DATA_W-1:0] compare;
      logic [ELAPSED_W-1:0]  elapsed;
      segment_left = 0;
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: compare = 8'd0;
            1: compare = 8'hFF;
            2: compare = CSR_DATA_W'(FINAL_LINE);
            3: compare = CSR_DATA_W'(VBLANK_AT);
            4: compare = CSR_DATA_W'(FINAL_LINE + 1);
            default: compare = CSR_DATA_W'($urandom_range(0, FINAL_LINE));
         endcase
         write_csr(CSR_VCOUNT_COMPARE, compare);
         write_csr(CSR_VBLANK_IRQ_EN,
                   enable_word(phase == 1 ? 1'b1 : phase == 0 ? 1'b0 : 1'($urandom)));
         write_csr(CSR_HBLANK_IRQ_EN,
                   enable_word(phase == 1 ? 1'b1 : phase == 0 ? 1'b0 : 1'($urandom)));
         write_csr(CSR_VMATCH_IRQ_EN,
                   enable_word(phase == 1 ? 1'b1 : phase == 0 ? 1'b0 : 1'($urandom)));
         for (int item = 0; item < 130; item++) begin
            // Every so often the pacing changes. Sometimes the sender also holds off until
            // the block has completely drained.
            if (segment_left == 0) begin
               segment_left = $urandom_range(15, 60);
               pick         = $urandom_range(0, 3);
               req_pacing   = pick[0];
               rsp_pacing   = pick[1];
               if ($urandom_range(0, 5) == 0)
                  wait_idle();
            end
            segment_left--;
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               elapsed = ELAPSED_W'($urandom_range(0, 4095));
            end else if (pick < 60) begin
               elapsed = ELAPSED_W'($urandom_range(0, 300));
            end else if (pick < 85) begin
               case ($urandom_range(0, 5))
                  0: elapsed = elapsed_to_reach(DRAW_PERIOD - 1);
                  1: elapsed = elapsed_to_reach(DRAW_PERIOD);
                  2: elapsed = elapsed_to_reach(LINE_PERIOD - 1);
                  3: elapsed = elapsed_to_reach(LINE_PERIOD);
                  4: elapsed = elapsed_to_reach(2 * LINE_PERIOD);
                  default: elapsed = elapsed_to_reach(4 * LINE_PERIOD);
               endcase
            end else begin
               elapsed = ELAPSED_W'(LINE_PERIOD * $urandom_range(1, 3));
            end
            send_elapsed(elapsed);
         end
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_elapsed_cycles = '0;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_VCOUNT_COMPARE;
      csr_write_data     = '0;
      line_cycles_model  = '0;
      line_model         = '0;
      hblank_model       = 1'b0;
      vblank_model       = 1'b0;
      match_model        = 1'b0;
      csr_model          = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The directed tests run with the sink stalling at random; the sender runs free only in the first of them.
      rsp_pacing = 1'b1;
      test_field_extremes();
      req_pacing = 1'b1;
      test_hblank_edge();
      test_line_match();
      test_random_frames();

      // Drain everything that is still outstanding, then give the block a few more cycles
      // so that any extra result it sends is caught as unexpected.
      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
